@@ hdl/pwd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwd_pkg: shared types and constants for the peer-wire message deframer
// Holds the result record, the handshake keyword table and framing constants.
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int unsigned KwLen    = 20;
  localparam int unsigned HsLen    = 68;
  localparam int unsigned PrefLen  = 4;
  localparam int unsigned OqDepth  = 4;
  localparam int unsigned OqPtrW   = $clog2(OqDepth);
  localparam int unsigned OqCntW   = $clog2(OqDepth + 1);

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        is_handshake;
    logic [7:0]  message_id;
    logic [31:0] message_length;
    logic        buffer_complete;
    logic [31:0] complete_bytes;
    logic        last_result;
  } res_t;

  // Push request from the parser into the result queue
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  // Byte of the handshake prefix at position idx (0 .. KwLen-1)
  function automatic logic [7:0] kw_byte(input logic [4:0] idx);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      5'd0:  b = 8'd19;
      5'd1:  b = 8'h42; // B
      5'd2:  b = 8'h69; // i
      5'd3:  b = 8'h74; // t
      5'd4:  b = 8'h54; // T
      5'd5:  b = 8'h6f; // o
      5'd6:  b = 8'h72; // r
      5'd7:  b = 8'h72; // r
      5'd8:  b = 8'h65; // e
      5'd9:  b = 8'h6e; // n
      5'd10: b = 8'h74; // t
      5'd11: b = 8'h20; // space
      5'd12: b = 8'h70; // p
      5'd13: b = 8'h72; // r
      5'd14: b = 8'h6f; // o
      5'd15: b = 8'h74; // t
      5'd16: b = 8'h6f; // o
      5'd17: b = 8'h63; // c
      5'd18: b = 8'h6f; // o
      5'd19: b = 8'h6c; // l
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/pwd_parse.sv @@
// ----------------------------------------------------------------------------
// pwd_parse: input register and framing state of the deframer
// Registers one byte, then frames it against the message state in one pass
// and hands up to two results to the result queue.
// ----------------------------------------------------------------------------
module pwd_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          buffer_end_i,
  input  logic          room_i,
  output pwd_pkg::push_t push_o
);
  import pwd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_end_q;
  logic        step;
  logic        accept;

  logic [32:0] bim_q, bim_d;
  logic [31:0] acc_q, acc_d;
  logic        kwm_q, kwm_d;
  logic        hsc_q, hsc_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] off_q, off_d;
  logic [31:0] lbo_q, lbo_d;

  logic [32:0] count;
  logic [31:0] acc_n;
  logic [7:0]  id_n;
  logic        kwm_n, hsc_n;
  logic        done, hs;
  logic [31:0] next_off, lbo_n;
  logic [4:0]  kw_idx;
  res_t        rep, stat;

  assign step       = s1_valid_q && room_i;
  assign in_stall_o = s1_valid_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_end_q  <= buffer_end_i;
    end
  end

  assign kw_idx = count[4:0] - 5'd1;

  always_comb begin
    count = bim_q + 33'd1;
    acc_n = (count <= 33'(PrefLen)) ? {acc_q[23:0], s1_byte_q} : acc_q;
    id_n  = (count == 33'(PrefLen + 1)) ? s1_byte_q : id_q;
    kwm_n = kwm_q;
    hsc_n = hsc_q;
    if (!hsc_q && kwm_q) begin
      if (count <= 33'(KwLen) && kw_byte(kw_idx) == s1_byte_q) begin
        if (count == 33'(KwLen)) begin
          hsc_n = 1'b1;
        end
      end else begin
        kwm_n = 1'b0;
      end
    end
    hs   = hsc_n && (count == 33'(HsLen));
    done = hsc_n ? hs
                 : (count >= 33'(PrefLen) && count == ({1'b0, acc_n} + 33'(PrefLen)));
    next_off = (off_q == '1) ? off_q : off_q + 32'd1;
    lbo_n    = done ? next_off : lbo_q;

    rep                 = '0;
    rep.kind            = KIND_REPORT;
    rep.is_handshake    = hs;
    rep.message_id      = (hs || acc_n == 32'd0) ? 8'd0 : id_n;
    rep.message_length  = hs ? 32'(HsLen) : acc_n;
    rep.last_result     = !s1_end_q;

    stat                 = '0;
    stat.kind            = KIND_STATUS;
    stat.buffer_complete = done;
    stat.complete_bytes  = lbo_n;
    stat.last_result     = 1'b1;

    push_o.num    = step ? (2'(done) + 2'(s1_end_q)) : 2'd0;
    push_o.first  = done ? rep : stat;
    push_o.second = stat;

    // next state
    bim_d = bim_q;
    acc_d = acc_q;
    kwm_d = kwm_q;
    hsc_d = hsc_q;
    id_d  = id_q;
    off_d = off_q;
    lbo_d = lbo_q;
    if (step) begin
      off_d = next_off;
      lbo_d = lbo_n;
      if (done) begin
        bim_d = '0;
        acc_d = '0;
        kwm_d = 1'b1;
        hsc_d = 1'b0;
        id_d  = '0;
      end else begin
        bim_d = count;
        acc_d = acc_n;
        kwm_d = kwm_n;
        hsc_d = hsc_n;
        id_d  = id_n;
      end
      // drop all framing state at the end of the buffer
      if (s1_end_q) begin
        bim_d = '0;
        acc_d = '0;
        kwm_d = 1'b1;
        hsc_d = 1'b0;
        id_d  = '0;
        off_d = '0;
        lbo_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bim_q <= '0;
      acc_q <= '0;
      kwm_q <= 1'b1;
      hsc_q <= 1'b0;
      id_q  <= '0;
      off_q <= '0;
      lbo_q <= '0;
    end else begin
      bim_q <= bim_d;
      acc_q <= acc_d;
      kwm_q <= kwm_d;
      hsc_q <= hsc_d;
      id_q  <= id_d;
      off_q <= off_d;
      lbo_q <= lbo_d;
    end
  end

endmodule

@@ hdl/pwd_outq.sv @@
// ----------------------------------------------------------------------------
// pwd_outq: result queue of the deframer
// Takes up to two results per cycle and presents one per transaction.
// ----------------------------------------------------------------------------
module pwd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwd_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pwd_pkg::res_t  head_o
);
  import pwd_pkg::*;

  res_t              mem_q [OqDepth];
  logic [OqPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OqCntW-1:0] cnt_q, cnt_d;
  logic [OqPtrW-1:0] wr_ptr_p1;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // keep space for a report and a status from one byte
  assign room_o      = (cnt_q <= OqCntW'(OqDepth - 2));
  assign wr_ptr_p1   = wr_ptr_q + OqPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OqPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + OqPtrW'(pop);
    cnt_d    = cnt_q + OqCntW'(push_i.num) - OqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.second;
    end
  end

endmodule

@@ hdl/peer_wire_message_deframer.sv @@
// ----------------------------------------------------------------------------
// peer_wire_message_deframer: splits a received byte buffer into peer-wire
// messages and reports each message plus an end-of-buffer status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o   | data_byte_i, buffer_end_i
//  out     | output    | out_valid_o/out_stall_i | result_kind_o .. last_result_o
//
//  One byte per cycle while the input does not stall: a byte is registered,
//  framed in a single pass, and its results (up to two) are written into a
//  four-entry result queue once it has room, and are taken from its head.
//  The input stalls only while the queue lacks room for two results, so a
//  sustained rate of one byte per cycle holds while results drain as fast.
//  Reset clears framing state and empties the queue; no clearing pass.
//  A stalled result stays at the head of the queue unchanged.
// ----------------------------------------------------------------------------
module peer_wire_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        is_handshake_o,
  output logic [7:0]  message_id_o,
  output logic [31:0] message_length_o,
  output logic        buffer_complete_o,
  output logic [31:0] complete_bytes_o,
  output logic        last_result_o
);
  import pwd_pkg::*;

  push_t push;
  logic  room;
  res_t  head;

  pwd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .buffer_end_i(buffer_end_i),
    .room_i      (room),
    .push_o      (push)
  );

  pwd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign result_kind_o     = head.kind;
  assign is_handshake_o    = head.is_handshake;
  assign message_id_o      = head.message_id;
  assign message_length_o  = head.message_length;
  assign buffer_complete_o = head.buffer_complete;
  assign complete_bytes_o  = head.complete_bytes;
  assign last_result_o     = head.last_result;

endmodule

@@ hdl/pwd_checker.sv @@
// ----------------------------------------------------------------------------
// pwd_checker: port-level checks for the peer-wire message deframer
// Watches the output channel for protocol and result consistency.
// ----------------------------------------------------------------------------
module pwd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic        is_handshake_o,
  input logic [7:0]  message_id_o,
  input logic [31:0] message_length_o,
  input logic        buffer_complete_o,
  input logic [31:0] complete_bytes_o,
  input logic        last_result_o
);
  import pwd_pkg::*;

  // a stalled transaction stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(message_length_o) &&
      $stable(complete_bytes_o) && $stable(result_kind_o))
    else $error("result changed while stalled");

  // a status is always the final result of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_STATUS |-> last_result_o &&
      !is_handshake_o && message_length_o == 32'd0)
    else $error("malformed status result");

  a_hs_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_REPORT && is_handshake_o |->
      message_length_o == 32'(HsLen) && message_id_o == 8'd0)
    else $error("malformed handshake report");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_REPORT |->
      !buffer_complete_o && complete_bytes_o == 32'd0 &&
      (message_length_o != 32'd0 || message_id_o == 8'd0))
    else $error("report carries status fields");

endmodule

bind peer_wire_message_deframer pwd_checker u_pwd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_o    (result_kind_o),
  .is_handshake_o   (is_handshake_o),
  .message_id_o     (message_id_o),
  .message_length_o (message_length_o),
  .buffer_complete_o(buffer_complete_o),
  .complete_bytes_o (complete_bytes_o),
  .last_result_o    (last_result_o)
);
